// ----- rtl/ffsa_pkg.sv -----
// Shared types and constants for the first-fit segment allocator.
// Used by ffsa_ctrl and first_fit_segment_allocator; no dependencies.
package ffsa_pkg;

   localparam int OFS_W            = 20;
   localparam int SIZE_W           = 21;
   localparam int SEG_W            = 8;
   localparam int CSR_DATA_W       = 21;
   localparam int CSR_IDX_W        = 1;
   localparam int DEF_MAX_BLOCKS   = 32;
   localparam int DEF_OFFSET_BITS  = 20;

   localparam logic [SIZE_W-1:0] SEG_MAX = 21'd1048576;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SEGMENT_SIZE = 1'b0,
      REG_SEGMENT_ID   = 1'b1
   } reg_index_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type             command;
      logic [SIZE_W-1:0]   request_size;
      logic [OFS_W-1:0]    free_offset;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [OFS_W-1:0]    block_offset;
      logic [SIZE_W-1:0]   block_size;
      logic [SEG_W-1:0]    segment_number;
   } rsp_type;

   typedef struct packed {
      status_type          status;
      logic [OFS_W-1:0]    block_offset;
      logic [SIZE_W-1:0]   block_size;
   } result_type;

   typedef struct packed {
      logic [OFS_W-1:0]    offset;
      logic [SIZE_W-1:0]   size;
      logic                free;
   } entry_type;

endpackage

// ----- rtl/ffsa_ctrl.sv -----
// Block table memory and the sequencer that scans, shifts and rewrites it.
// Depends on ffsa_pkg.
module ffsa_ctrl #(
   parameter int MAX_BLOCKS  = ffsa_pkg::DEF_MAX_BLOCKS,
   parameter int OFFSET_BITS = ffsa_pkg::DEF_OFFSET_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        init_req,
   input  logic [ffsa_pkg::SIZE_W-1:0] seg_size,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ffsa_pkg::req_type           req_payload,
   input  logic                        out_ready,
   output logic                        res_valid,
   output ffsa_pkg::result_type        res
);
   import ffsa_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
   localparam logic [OFS_W-1:0] OFS_MASK = (OFFSET_BITS >= OFS_W) ? {OFS_W{1'b1}} :
      OFS_W'((64'd1 << OFFSET_BITS) - 64'd1);

   typedef enum logic [10:0] {
      S_INIT  = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_SCAN  = 11'b000_0000_0100,
      S_SHUP  = 11'b000_0000_1000,
      S_SPLIT = 11'b000_0001_0000,
      S_MARK  = 11'b000_0010_0000,
      S_NEXT  = 11'b000_0100_0000,
      S_JOIN  = 11'b000_1000_0000,
      S_SHDN  = 11'b001_0000_0000,
      S_MERGE = 11'b010_0000_0000,
      S_RESP  = 11'b100_0000_0000
   } state_type;

   entry_type mem [MAX_BLOCKS];
   entry_type rdata_ff;

   logic            mem_we;
   logic [IW-1:0]   mem_waddr;
   logic [IW-1:0]   mem_raddr;
   entry_type       mem_wdata;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      start_ff, start_in;
   logic [CW-1:0]      wr_ptr_ff, wr_ptr_in;
   cmd_type            cmd_ff, cmd_in;
   logic [SIZE_W-1:0]  req_size_ff, req_size_in;
   logic [OFS_W-1:0]   ofs_ff, ofs_in;
   entry_type          cur_ff, cur_in;
   entry_type          prev_ff, prev_in;
   logic               pf_ff, pf_in;
   logic               nf_ff, nf_in;
   logic [SIZE_W-1:0]  tot_ff, tot_in;
   logic [OFS_W-1:0]   base_ff, base_in;
   result_type         res_ff, res_in;

   logic               hit;
   logic               more;
   logic               pf_now;
   logic [1:0]         rem;
   logic [CW-1:0]      src;

   always_comb begin
      rem = {1'b0, pf_ff} + {1'b0, nf_ff};
      more = (CW'(idx_ff) + CW'(1)) < cnt_ff;
      pf_now = (idx_ff != '0) && prev_ff.free;
      if (cmd_ff == CMD_ALLOC) begin
         hit = rdata_ff.free && (rdata_ff.size >= req_size_ff);
      end else begin
         hit = rdata_ff.offset == ofs_ff;
      end
      src = '0;

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      start_in    = start_ff;
      wr_ptr_in   = wr_ptr_ff;
      cmd_in      = cmd_ff;
      req_size_in = req_size_ff;
      ofs_in      = ofs_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      pf_in       = pf_ff;
      nf_in       = nf_ff;
      tot_in      = tot_ff;
      base_in     = base_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '0;
      mem_raddr   = '0;
      res_valid   = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = '{offset: '0, size: seg_size, free: 1'b1};
            cnt_in    = CW'(1);
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_payload.command;
               req_size_in = req_payload.request_size;
               ofs_in      = req_payload.free_offset & OFS_MASK;
               idx_in      = '0;
               if (req_payload.command == CMD_ALLOC && req_payload.request_size == '0) begin
                  res_in   = '{status: ST_NO_FIT, block_offset: '0, block_size: '0};
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            prev_in = rdata_ff;
            if (hit) begin
               cur_in = rdata_ff;
               if (cmd_ff == CMD_ALLOC) begin
                  if (rdata_ff.size > req_size_ff) begin
                     if (cnt_ff == CNT_MAX) begin
                        res_in   = '{status: ST_FULL, block_offset: '0, block_size: '0};
                        state_in = S_RESP;
                     end else if (more) begin
                        mem_raddr = IW'(cnt_ff - CW'(1));
                        wr_ptr_in = cnt_ff;
                        state_in  = S_SHUP;
                     end else begin
                        state_in = S_SPLIT;
                     end
                  end else begin
                     state_in = S_MARK;
                  end
               end else begin
                  pf_in    = pf_now;
                  tot_in   = rdata_ff.size + (pf_now ? prev_ff.size : '0);
                  base_in  = pf_now ? prev_ff.offset : rdata_ff.offset;
                  start_in = pf_now ? idx_ff - IW'(1) : idx_ff;
                  if (more) begin
                     mem_raddr = idx_ff + IW'(1);
                     state_in  = S_NEXT;
                  end else begin
                     nf_in    = 1'b0;
                     state_in = S_JOIN;
                  end
               end
            end else if (more) begin
               mem_raddr = idx_ff + IW'(1);
               idx_in    = idx_ff + IW'(1);
            end else begin
               res_in = '{status: (cmd_ff == CMD_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND,
                          block_offset: '0, block_size: '0};
               state_in = S_RESP;
            end
         end
         S_SHUP: begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_ff[IW-1:0];
            mem_wdata = rdata_ff;
            if (wr_ptr_ff > CW'(idx_ff) + CW'(2)) begin
               mem_raddr = IW'(wr_ptr_ff - CW'(2));
               wr_ptr_in = wr_ptr_ff - CW'(1);
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff + IW'(1);
            mem_wdata = '{offset: cur_ff.offset + OFS_W'(req_size_ff),
                          size: cur_ff.size - req_size_ff, free: 1'b1};
            cnt_in    = cnt_ff + CW'(1);
            state_in  = S_MARK;
         end
         S_MARK: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '{offset: cur_ff.offset, size: req_size_ff, free: 1'b0};
            res_in    = '{status: ST_OK, block_offset: cur_ff.offset & OFS_MASK,
                          block_size: req_size_ff};
            state_in  = S_RESP;
         end
         S_NEXT: begin
            nf_in    = rdata_ff.free;
            tot_in   = tot_ff + (rdata_ff.free ? rdata_ff.size : '0);
            state_in = S_JOIN;
         end
         S_JOIN: begin
            src = CW'(start_ff) + CW'(1) + CW'(rem);
            if (rem != 2'd0 && src < cnt_ff) begin
               mem_raddr = src[IW-1:0];
               wr_ptr_in = CW'(start_ff) + CW'(1);
               state_in  = S_SHDN;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_SHDN: begin
            mem_we    = 1'b1;
            mem_waddr = wr_ptr_ff[IW-1:0];
            mem_wdata = rdata_ff;
            src = wr_ptr_ff + CW'(1) + CW'(rem);
            if (src < cnt_ff) begin
               mem_raddr = src[IW-1:0];
               wr_ptr_in = wr_ptr_ff + CW'(1);
            end else begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            mem_we    = 1'b1;
            mem_waddr = start_ff;
            mem_wdata = '{offset: base_ff, size: tot_ff, free: 1'b1};
            cnt_in    = cnt_ff - CW'(rem);
            res_in    = '{status: ST_OK, block_offset: base_ff & OFS_MASK, block_size: tot_ff};
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (out_ready) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      if (init_req) begin
         state_in = S_INIT;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= CW'(1);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      start_ff    <= start_in;
      wr_ptr_ff   <= wr_ptr_in;
      cmd_ff      <= cmd_in;
      req_size_ff <= req_size_in;
      ofs_ff      <= ofs_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      pf_ff       <= pf_in;
      nf_ff       <= nf_in;
      tot_ff      <= tot_in;
      base_ff     <= base_in;
      res_ff      <= res_in;
   end

endmodule

// ----- rtl/first_fit_segment_allocator.sv -----
// Top level: configuration registers, table sequencer and result register.
// Depends on ffsa_pkg and ffsa_ctrl.
//
//   port group     dir   handshake          payload
//   req_*          in    req_valid/stall    ffsa_pkg::req_type
//   rsp_*          out   rsp_valid/stall    ffsa_pkg::rsp_type
//   csr_*          in    csr_write_en       csr_index, csr_wdata
//
// A request scans the table entries in order (one read a cycle from the
// single read port of the table), then shifts entries up on a split or down
// on a merge and rewrites the split, marked or merged entries.
// After reset or a segment_size write the table is reset to one free
// block. A waiting result does not block the next request.
module first_fit_segment_allocator #(
   parameter int MAX_BLOCKS  = ffsa_pkg::DEF_MAX_BLOCKS,
   parameter int OFFSET_BITS = ffsa_pkg::DEF_OFFSET_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ffsa_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ffsa_pkg::rsp_type                rsp_payload,
   input  logic                             csr_write_en,
   input  logic [ffsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ffsa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ffsa_pkg::*;

   logic [SIZE_W-1:0] seg_size_ff, seg_size_in;
   logic [SEG_W-1:0]  seg_id_ff, seg_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              init_req;
   logic              out_ready;
   logic              res_valid;
   result_type        res;

   always_comb begin
      seg_size_in = seg_size_ff;
      seg_id_in   = seg_id_ff;
      init_req    = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_SEGMENT_SIZE: begin
               init_req = 1'b1;
               if (csr_wdata == '0) begin
                  seg_size_in = SIZE_W'(1);
               end else if (csr_wdata > SEG_MAX) begin
                  seg_size_in = SEG_MAX;
               end else begin
                  seg_size_in = csr_wdata;
               end
            end
            REG_SEGMENT_ID: begin
               seg_id_in = csr_wdata[SEG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{status: res.status, block_offset: res.block_offset,
                          block_size: res.block_size, segment_number: seg_id_ff};
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   ffsa_ctrl #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .init_req    (init_req),
      .seg_size    (seg_size_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_ready   (out_ready),
      .res_valid   (res_valid),
      .res         (res)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_size_ff  <= SEG_MAX;
         seg_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_size_ff  <= seg_size_in;
         seg_id_ff    <= seg_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for first_fit_segment_allocator: random and directed
// allocate/free requests checked against an in-bench block table predictor.
// Depends on ffsa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;
   import ffsa_pkg::*;

   localparam int TABLE_DEPTH = DEF_MAX_BLOCKS;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 20;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the block table and registers
   entry_type             blk [TABLE_DEPTH];
   int                    blk_count;
   logic [SIZE_W-1:0]     seg_size;
   logic [SEG_W-1:0]      seg_id;

   req_type               cmd_backlog [$];
   rsp_type               owed_blocks [$];
   logic                  req_fire = 1'b0;
   int                    req_gap = 0;
   int                    hold_left = 0;
   int                    open_left = 0;
   bit                    no_idle = 1'b0;
   bit                    pressure_go = 1'b0;
   bit                    pressure_done = 1'b0;
   int                    errors = 0;

   first_fit_segment_allocator dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(15_000_000);
      $display("first_fit_segment_allocator: mismatch");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void rebuild_table();
      int k;
      for (k = 0; k < TABLE_DEPTH; k++) blk[k] = '0;
      blk[0].size = seg_size;
      blk[0].free = 1'b1;
      blk_count = 1;
   endfunction

   // one result per request; updates the table copy
   function automatic rsp_type predict_block(req_type item);
      rsp_type           r;
      int                hit, lo, hi, gone, k;
      logic [SIZE_W-1:0] total;
      r.status = ST_NO_FIT;
      r.block_offset = '0;
      r.block_size = '0;
      r.segment_number = seg_id;
      hit = -1;
      if (item.command == CMD_ALLOC) begin
         for (k = 0; k < blk_count && hit < 0; k++)
            if (item.request_size != 0 && blk[k].free && blk[k].size >= item.request_size)
               hit = k;
         if (hit >= 0 && blk[hit].size > item.request_size && blk_count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else if (hit >= 0) begin
            if (blk[hit].size > item.request_size) begin
               for (k = blk_count; k > hit + 1; k--) blk[k] = blk[k-1];
               blk[hit+1].offset = blk[hit].offset + item.request_size[OFS_W-1:0];
               blk[hit+1].size = blk[hit].size - item.request_size;
               blk[hit+1].free = 1'b1;
               blk_count++;
            end
            blk[hit].size = item.request_size;
            blk[hit].free = 1'b0;
            r.status = ST_OK;
            r.block_offset = blk[hit].offset;
            r.block_size = item.request_size;
         end
      end else begin
         for (k = 0; k < blk_count && hit < 0; k++)
            if (blk[k].offset == item.free_offset) hit = k;
         if (hit < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            blk[hit].free = 1'b1;
            lo = hit;
            while (lo > 0 && blk[lo-1].free) lo--;
            hi = lo;
            total = '0;
            while (hi < blk_count && blk[hi].free) begin
               total += blk[hi].size;
               hi++;
            end
            gone = hi - lo - 1;
            for (k = lo + 1; k + gone < blk_count; k++) blk[k] = blk[k+gone];
            for (k = blk_count - gone; k < blk_count; k++) blk[k] = '0;
            blk_count -= gone;
            blk[lo].size = total;
            blk[lo].free = 1'b1;
            r.status = ST_OK;
            r.block_offset = blk[lo].offset;
            r.block_size = total;
         end
      end
      return r;
   endfunction

   function automatic req_type make_request(cmd_type c, int unsigned sz, int unsigned ofs);
      req_type item;
      item.command = c;
      item.request_size = SIZE_W'(sz);
      item.free_offset = OFS_W'(ofs);
      return item;
   endfunction

   function automatic void queue_request(req_type item);
      cmd_backlog.insert(cmd_backlog.size(), item);
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      logic [CSR_DATA_W-1:0] v;
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == REG_SEGMENT_SIZE) begin
         v = val;
         if (v == 0) v = 1;
         else if (v > SEG_MAX) v = SEG_MAX;
         seg_size = v;
         rebuild_table();
      end else begin
         seg_id = val[SEG_W-1:0];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic settle();
      while (cmd_backlog.size() != 0 || req_valid || owed_blocks.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] sz, input logic [SEG_W-1:0] id,
                            input int alloc_pct, input int n, input bit calm, input bit press);
      req_type item;
      int      j, r, pick;
      settle();
      write_reg(REG_SEGMENT_SIZE, sz);
      write_reg(REG_SEGMENT_ID, {13'($urandom), id});
      no_idle = calm;
      for (j = 0; j < n; j++) begin
         while (cmd_backlog.size() >= 2) @(negedge clock);
         if (press && j == 4) pressure_go = 1'b1;
         item.request_size = SIZE_W'($urandom);
         item.free_offset = OFS_W'($urandom);
         r = $urandom_range(0, 99);
         pick = $urandom_range(0, blk_count - 1);
         if ($urandom_range(0, 99) < alloc_pct) begin
            item.command = CMD_ALLOC;
            if (r < 4) item.request_size = '0;
            else if (r < 8) item.request_size = seg_size + SIZE_W'($urandom_range(1, 64));
            else if (r < 26) item.request_size = blk[pick].size;
            else if (r < 76)
               item.request_size = SIZE_W'($urandom_range(1, int'(seg_size) / 48 + 1));
            else if (r < 92) item.request_size = SIZE_W'($urandom_range(1, int'(seg_size)));
         end else begin
            item.command = CMD_FREE;
            if (r < 75) item.free_offset = blk[pick].offset;
            else if (r < 88) item.free_offset = blk[pick].offset + 1'b1;
         end
         queue_request(item);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (cmd_backlog.size() != 0) begin
            req_payload <= cmd_backlog.pop_front();
            req_valid <= 1'b1;
            req_gap = no_idle ? 0 : idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (pressure_go && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = 400;
            open_left = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (open_left > 0) begin
            rsp_stall <= 1'b0;
            open_left--;
         end else begin
            rsp_stall <= 1'b0;
            open_left = $urandom_range(0, 8);
            hold_left = no_idle ? 0 : idle_len();
         end
      end
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            owed_blocks.insert(owed_blocks.size(), predict_block(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (owed_blocks.size() == 0) begin
               errors++;
               $display("%0t: unexpected response st=%0d ofs=%0d size=%0d seg=%0d", $time,
                        rsp_payload.status, rsp_payload.block_offset,
                        rsp_payload.block_size, rsp_payload.segment_number);
            end else begin
               want = owed_blocks.pop_front();
               if (rsp_payload.status !== want.status ||
                   rsp_payload.block_offset !== want.block_offset ||
                   rsp_payload.block_size !== want.block_size ||
                   rsp_payload.segment_number !== want.segment_number) begin
                  errors++;
                  $display("%0t: exp st=%0d ofs=%0d sz=%0d seg=%0d got st=%0d ofs=%0d sz=%0d seg=%0d",
                           $time, want.status, want.block_offset, want.block_size,
                           want.segment_number, rsp_payload.status,
                           rsp_payload.block_offset, rsp_payload.block_size,
                           rsp_payload.segment_number);
               end
            end
         end
      end
   end

   initial begin
      seg_size = SEG_MAX;
      seg_id = '0;
      rebuild_table();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default segment of 1 MiB
      queue_request(make_request(CMD_ALLOC, 0, 20'hFFFFF));
      queue_request(make_request(CMD_ALLOC, 21'h1FFFFF, 0));
      queue_request(make_request(CMD_ALLOC, 1048577, $urandom));
      queue_request(make_request(CMD_ALLOC, 1048576, $urandom));
      queue_request(make_request(CMD_ALLOC, 1, $urandom));
      queue_request(make_request(CMD_FREE, 21'h1FFFFF, 0));
      queue_request(make_request(CMD_FREE, 0, 0));
      queue_request(make_request(CMD_FREE, $urandom, 5));
      queue_request(make_request(CMD_FREE, $urandom, 20'hFFFFF));
      queue_request(make_request(CMD_ALLOC, 100, $urandom));
      queue_request(make_request(CMD_ALLOC, 200, $urandom));
      queue_request(make_request(CMD_ALLOC, 300, $urandom));
      queue_request(make_request(CMD_FREE, $urandom, 100));
      queue_request(make_request(CMD_FREE, $urandom, 0));
      queue_request(make_request(CMD_ALLOC, 300, $urandom));
      queue_request(make_request(CMD_FREE, $urandom, 300));
      queue_request(make_request(CMD_FREE, $urandom, 0));

      run_phase(21'd0, 8'd255, 50, 30, 1'b0, 1'b0);
      run_phase(21'h1FFFFF, 8'h5A, 60, 250, 1'b0, 1'b0);
      run_phase(21'd64, 8'hA5, 85, 300, 1'b1, 1'b0);
      run_phase(21'd1048576, 8'd0, 55, 400, 1'b0, 1'b1);
      run_phase(21'd1000, 8'($urandom), 65, 300, 1'b0, 1'b0);
      run_phase(21'($urandom_range(2, 1048576)), 8'($urandom), 50, 250, 1'b0, 1'b0);
      run_phase(21'd1, 8'd255, 50, 20, 1'b0, 1'b0);
      settle();

      if (errors == 0)
         $display("first_fit_segment_allocator: match");
      else
         $display("first_fit_segment_allocator: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ffsa_pkg.sv
rtl/ffsa_ctrl.sv
rtl/first_fit_segment_allocator.sv
bench/tb_top.sv
